/* hw/rtl/sdwe_pkg.sv */
// ----------------------------------------------------------------------------
// sdwe_pkg: shared definitions of the stereo watermark embedder
// Widths, reset values, input kinds and the saturating channel add.
// ----------------------------------------------------------------------------
package sdwe_pkg;

	localparam int MAX_ROW_WIDTH_DEF = 1024;
	localparam int CFG_W             = 11;
	localparam int CH_W              = 8;
	localparam int PIX_W             = 3 * CH_W;
	localparam int DISP_W            = 8;
	localparam int TAG_W             = 24;
	localparam int ROW_WIDTH_RESET   = 640;
	localparam int IN_DATA_W         = 3 * PIX_W + DISP_W;
	localparam int OUT_DATA_W        = 2 * PIX_W;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	function automatic logic [CH_W-1:0] sat_add(input logic [CH_W-1:0] a,
			input logic [CH_W-1:0] b);
		logic [CH_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CH_W] ? {CH_W{1'b1}} : s[CH_W-1:0];
	endfunction

	function automatic logic [PIX_W-1:0] sat_add_pix(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b);
		return {sat_add(a[23:16], b[23:16]), sat_add(a[15:8], b[15:8]),
			sat_add(a[7:0], b[7:0])};
	endfunction

endpackage

/* hw/rtl/sdwe_ram.sv */
// ----------------------------------------------------------------------------
// sdwe_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sdwe_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/stereo_disparity_watermark_embed.sv */
// ----------------------------------------------------------------------------
// stereo_disparity_watermark_embed: additive stereo watermark embedder
// Adds a watermark to the left view and a disparity-shifted copy of it to
// the right view, the right view leaving one row late.
// ----------------------------------------------------------------------------
// The block takes one pixel transaction per clock while the output is not
// stalled and the store clearing after reset is done, and returns one
// result per transaction. The result passes the input stage and then the
// output register before it is offered. The input stage registers the
// transaction together with the row store reads, and the output register
// holds the sums. While a result waits, the input stage can still take one
// more transaction; after that s_tready follows m_tready. The left result is
// the current pixel, the right result is the pixel of the previous row at
// the same column, read from double-banked row stores (one write and one
// read port each). After reset the block clears all DEPTH entries of the
// moved-mark store and accepts no pixels while it does so; the width
// register can be written at any time. Flush transactions drain the last row.
module stereo_disparity_watermark_embed #(
	parameter int MAX_ROW_WIDTH = sdwe_pkg::MAX_ROW_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sdwe_pkg::CFG_W-1:0]     cfg_data,      // row_width
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// left_blue, left_green, left_red, right_blue, right_green, right_red,
	// mark_blue, mark_green, mark_red, disparity
	input  logic [sdwe_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic [0:0]                     s_tuser,       // kind
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// out_left_blue, out_left_green, out_left_red,
	// out_right_blue, out_right_green, out_right_red
	output logic [sdwe_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [1:0]                     m_tuser,       // left_out_valid, right_out_valid
	output logic                           m_tlast        // row_end
);
	import sdwe_pkg::*;

	localparam int CW    = $clog2(MAX_ROW_WIDTH);
	localparam int WW    = CW + 1;
	localparam int XW    = (WW > CFG_W) ? WW : CFG_W;
	localparam int DW    = (CW > DISP_W) ? CW : DISP_W;
	localparam int DEPTH = 2 ** (CW + 1);
	localparam int AW    = CW + 1;
	localparam int MW    = TAG_W + PIX_W;
	localparam int RST_W = (ROW_WIDTH_RESET > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH
		: ROW_WIDTH_RESET;

	logic [WW-1:0]    row_width_q;
	logic [CW-1:0]    col_q;
	logic             bank_q;
	logic             pending_q;
	logic [TAG_W-1:0] tag0_q, tag1_q, tag_ctr_q;
	logic             clr_busy_q;
	logic [AW-1:0]    clr_addr_q;

	logic             v_s1, lvalid_s1, rvalid_s1, last_s1;
	logic [PIX_W-1:0] left_s1, mark_s1;
	logic [TAG_W-1:0] ptag_s1;

	logic             accept, advance, is_flush, empty_flush, last, col0_pixel;
	logic [XW-1:0]    cfg_ext;
	logic [WW-1:0]    cfg_clamped;
	logic [WW-1:0]    col_next;
	logic [DW-1:0]    col_ext, disp_ext, moved_ext;
	logic             mark_hit;
	logic [TAG_W-1:0] cur_tag, prev_tag, tag_wr, tag_ctr_next;
	logic [PIX_W-1:0] in_left, in_right, in_mark;
	logic [DISP_W-1:0] in_disp;

	logic             mark_we;
	logic [AW-1:0]    mark_waddr, rd_addr;
	logic [MW-1:0]    mark_wdata, mark_rdata;
	logic [PIX_W-1:0] right_rdata, moved_mark;

	assign cfg_ready = 1'b1;

	assign in_left  = s_tdata[PIX_W-1:0];
	assign in_right = s_tdata[2*PIX_W-1:PIX_W];
	assign in_mark  = s_tdata[3*PIX_W-1:2*PIX_W];
	assign in_disp  = s_tdata[IN_DATA_W-1:3*PIX_W];
	assign is_flush = (s_tuser[0] == KIND_FLUSH);

	assign advance  = !m_tvalid || m_tready;
	assign s_tready = !clr_busy_q && (!v_s1 || advance);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cfg_ext = XW'(cfg_data);
		if (cfg_ext == '0) begin
			cfg_clamped = WW'(1);
		end else if (cfg_ext > XW'(MAX_ROW_WIDTH)) begin
			cfg_clamped = WW'(MAX_ROW_WIDTH);
		end else begin
			cfg_clamped = cfg_ext[WW-1:0];
		end
	end

	assign empty_flush = is_flush && !pending_q && (col_q == '0);
	assign col_next    = {1'b0, col_q} + WW'(1);
	assign last        = (col_next >= row_width_q);
	assign col0_pixel  = !is_flush && (col_q == '0);

	assign col_ext   = DW'(col_q);
	assign disp_ext  = DW'(in_disp);
	assign moved_ext = col_ext - disp_ext;
	assign mark_hit  = (disp_ext <= col_ext);

	assign cur_tag      = bank_q ? tag1_q : tag0_q;
	assign prev_tag     = bank_q ? tag0_q : tag1_q;
	assign tag_wr       = col0_pixel ? tag_ctr_q : cur_tag;
	assign tag_ctr_next = (tag_ctr_q == {TAG_W{1'b1}}) ? TAG_W'(1) : tag_ctr_q + TAG_W'(1);

	assign rd_addr = {~bank_q, col_q};

	always_comb begin
		if (clr_busy_q) begin
			mark_we    = 1'b1;
			mark_waddr = clr_addr_q;
			mark_wdata = '0;
		end else begin
			mark_we    = accept && !is_flush && mark_hit;
			mark_waddr = {bank_q, moved_ext[CW-1:0]};
			mark_wdata = {tag_wr, in_mark};
		end
	end

	sdwe_ram #(
		.WIDTH (PIX_W),
		.DEPTH (DEPTH)
	) u_right_ram (
		.clk   (clk),
		.we    (accept && !is_flush),
		.waddr ({bank_q, col_q}),
		.wdata (in_right),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (right_rdata)
	);

	sdwe_ram #(
		.WIDTH (MW),
		.DEPTH (DEPTH)
	) u_mark_ram (
		.clk   (clk),
		.we    (mark_we),
		.waddr (mark_waddr),
		.wdata (mark_wdata),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (mark_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= WW'(RST_W);
		end else if (cfg_valid && cfg_ready) begin
			row_width_q <= cfg_clamped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			bank_q    <= 1'b0;
			pending_q <= 1'b0;
			tag0_q    <= TAG_W'(1);
			tag1_q    <= TAG_W'(1);
			tag_ctr_q <= TAG_W'(2);
		end else if (accept && !empty_flush) begin
			if (col0_pixel) begin
				tag_ctr_q <= tag_ctr_next;
				if (bank_q) begin
					tag1_q <= tag_ctr_q;
				end else begin
					tag0_q <= tag_ctr_q;
				end
			end
			if (last) begin
				col_q     <= '0;
				bank_q    <= ~bank_q;
				pending_q <= !is_flush;
			end else begin
				col_q <= col_next[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lvalid_s1 <= !is_flush;
			rvalid_s1 <= pending_q;
			last_s1   <= !empty_flush && last;
			left_s1   <= in_left;
			mark_s1   <= in_mark;
			ptag_s1   <= prev_tag;
		end
	end

	assign moved_mark = (mark_rdata[MW-1:PIX_W] == ptag_s1) ? mark_rdata[PIX_W-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s1) begin
			m_tdata[PIX_W-1:0]       <= lvalid_s1 ? sat_add_pix(left_s1, mark_s1) : '0;
			m_tdata[2*PIX_W-1:PIX_W] <= rvalid_s1 ? sat_add_pix(right_rdata, moved_mark) : '0;
			m_tuser                  <= {rvalid_s1, lvalid_s1};
			m_tlast                  <= last_s1;
		end
	end

endmodule
